@@ rtl/core/ucc_pkg.sv @@
package ucc_pkg;

    localparam int TABLE_DEPTH = 65536;
    localparam int TABLE_AW    = $clog2(TABLE_DEPTH);
    localparam int CHAR_W      = 16;
    localparam int LEN_W       = 8;
    localparam int VERDICT_W   = 8;
    localparam int ULEN_W      = 17;
    localparam int APB_AW      = 4;
    localparam int APB_DW      = 32;

    // Characters at or above this value are never invalid.
    localparam int BAD_CHAR_LIMIT = 64;
    // One bit for each of '"', '*', '<', '>' and '?'.
    localparam logic [BAD_CHAR_LIMIT-1:0] BAD_CHAR_MASK =
        (64'd1 << 8'h22) | (64'd1 << 8'h2A) | (64'd1 << 8'h3C) |
        (64'd1 << 8'h3E) | (64'd1 << 8'h3F);

    localparam logic signed [VERDICT_W-1:0] VERDICT_LESS    = -8'sd1;
    localparam logic signed [VERDICT_W-1:0] VERDICT_EQUAL   = 8'sd0;
    localparam logic signed [VERDICT_W-1:0] VERDICT_GREATER = 8'sd1;
    localparam logic signed [VERDICT_W-1:0] ERROR_RESET     = -8'sd2;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_COMPARE = 2'd1,
        CMD_FINISH  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        REG_CASE_FOLD     = 2'd0,
        REG_UPCASE_LENGTH = 2'd1,
        REG_ERROR_VALUE   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic                        case_fold;
        logic [ULEN_W-1:0]           upcase_length;
        logic signed [VERDICT_W-1:0] error_value;
    } cfg_t;

    function automatic logic is_bad_char(input logic [CHAR_W-1:0] c);
        logic in_range;
        in_range = (32'(c) < BAD_CHAR_LIMIT);
        return in_range && BAD_CHAR_MASK[c[$clog2(BAD_CHAR_LIMIT)-1:0]];
    endfunction

endpackage

@@ rtl/core/ucc_item_if.sv @@
interface ucc_item_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     command;
    logic [ucc_pkg::CHAR_W-1:0]     table_index;
    logic [ucc_pkg::CHAR_W-1:0]     table_value;
    logic [ucc_pkg::CHAR_W-1:0]     char_first;
    logic [ucc_pkg::CHAR_W-1:0]     char_second;
    logic [ucc_pkg::LEN_W-1:0]      first_length;
    logic [ucc_pkg::LEN_W-1:0]      second_length;

    modport source
    (
        output valid, command, table_index, table_value, char_first, char_second,
               first_length, second_length,
        input  ready
    );

    modport sink
    (
        input  valid, command, table_index, table_value, char_first, char_second,
               first_length, second_length,
        output ready
    );
endinterface

@@ rtl/core/ucc_result_if.sv @@
interface ucc_result_if;
    logic                                valid;
    logic                                ready;
    logic                                decided;
    logic signed [ucc_pkg::VERDICT_W-1:0] verdict;

    modport source
    (
        output valid, decided, verdict,
        input  ready
    );

    modport sink
    (
        input  valid, decided, verdict,
        output ready
    );
endinterface

@@ rtl/core/ucc_ram.sv @@
module ucc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

@@ rtl/core/ucc_cfg.sv @@
module ucc_cfg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ucc_pkg::APB_AW-1:0]  paddr,
    input  logic [ucc_pkg::APB_DW-1:0]  pwdata,
    output logic [ucc_pkg::APB_DW-1:0]  prdata,
    output logic                        pready,
    output ucc_pkg::cfg_t               cfg
);

    logic                                 case_fold_reg;
    logic                                 case_fold_next;
    logic [ucc_pkg::ULEN_W-1:0]           upcase_length_reg;
    logic [ucc_pkg::ULEN_W-1:0]           upcase_length_next;
    logic signed [ucc_pkg::VERDICT_W-1:0] error_value_reg;
    logic signed [ucc_pkg::VERDICT_W-1:0] error_value_next;
    logic                                 wr_en;
    logic [1:0]                           reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        case_fold_next     = case_fold_reg;
        upcase_length_next = upcase_length_reg;
        error_value_next   = error_value_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                ucc_pkg::REG_CASE_FOLD:     case_fold_next     = pwdata[0];
                ucc_pkg::REG_UPCASE_LENGTH: upcase_length_next = pwdata[ucc_pkg::ULEN_W-1:0];
                ucc_pkg::REG_ERROR_VALUE:   error_value_next   = pwdata[ucc_pkg::VERDICT_W-1:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            ucc_pkg::REG_CASE_FOLD:     prdata = {31'd0, case_fold_reg};
            ucc_pkg::REG_UPCASE_LENGTH: prdata = {15'd0, upcase_length_reg};
            ucc_pkg::REG_ERROR_VALUE:   prdata = {24'd0, error_value_reg};
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            case_fold_reg     <= 1'b0;
            upcase_length_reg <= '0;
            error_value_reg   <= ucc_pkg::ERROR_RESET;
        end
        else
        begin
            case_fold_reg     <= case_fold_next;
            upcase_length_reg <= upcase_length_next;
            error_value_reg   <= error_value_next;
        end
    end

    assign cfg.case_fold     = case_fold_reg;
    assign cfg.upcase_length = upcase_length_reg;
    assign cfg.error_value   = error_value_reg;

endmodule

@@ rtl/core/ucc_core.sv @@
module ucc_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  ucc_pkg::cfg_t      cfg,
    ucc_item_if.sink           item,
    ucc_result_if.source       result
);

    localparam int AW = ucc_pkg::TABLE_AW;
    localparam int CW = ucc_pkg::CHAR_W;
    localparam int LW = ucc_pkg::LEN_W;
    localparam int VW = ucc_pkg::VERDICT_W;

    logic          accept;
    logic          advance;
    logic          tbl_we;
    logic [CW-1:0] rd_first;
    logic [CW-1:0] rd_second;

    logic          s1_valid_reg;
    logic          s1_valid_next;
    logic [1:0]    s1_cmd_reg;
    logic [CW-1:0] s1_first_reg;
    logic [CW-1:0] s1_second_reg;
    logic [LW-1:0] s1_len1_reg;
    logic [LW-1:0] s1_len2_reg;

    logic                 settled_reg;
    logic                 settled_next;
    logic signed [VW-1:0] held_reg;
    logic signed [VW-1:0] held_next;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic                 out_decided_reg;
    logic                 out_decided_next;
    logic signed [VW-1:0] out_verdict_reg;
    logic signed [VW-1:0] out_verdict_next;

    logic [CW-1:0]        map_first;
    logic [CW-1:0]        map_second;
    logic signed [VW-1:0] finish_verdict;

    assign advance    = s1_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready = !s1_valid_reg || advance;
    assign accept     = item.valid && item.ready;
    assign tbl_we     = accept && (item.command == ucc_pkg::CMD_LOAD)
                        && (32'(item.table_index) < ucc_pkg::TABLE_DEPTH);

    // Both characters are looked up as the beat is taken; the data lands
    // together with the beat in the compare stage.
    ucc_ram #(
        .WIDTH (CW),
        .DEPTH (ucc_pkg::TABLE_DEPTH)
    ) u_table
    (
        .clk     (clk),
        .we      (tbl_we),
        .waddr   (item.table_index[AW-1:0]),
        .wdata   (item.table_value),
        .re      (accept),
        .raddr_a (item.char_first[AW-1:0]),
        .raddr_b (item.char_second[AW-1:0]),
        .rdata_a (rd_first),
        .rdata_b (rd_second)
    );

    always_comb
    begin
        map_first = s1_first_reg;
        if (cfg.case_fold && ({1'b0, s1_first_reg} < cfg.upcase_length)
            && (32'(s1_first_reg) < ucc_pkg::TABLE_DEPTH))
        begin
            map_first = rd_first;
        end
        map_second = s1_second_reg;
        if (cfg.case_fold && ({1'b0, s1_second_reg} < cfg.upcase_length)
            && (32'(s1_second_reg) < ucc_pkg::TABLE_DEPTH))
        begin
            map_second = rd_second;
        end
    end

    always_comb
    begin
        if (settled_reg)
        begin
            finish_verdict = held_reg;
        end
        else if (s1_len1_reg < s1_len2_reg)
        begin
            finish_verdict = ucc_pkg::VERDICT_LESS;
        end
        else if (s1_len1_reg == s1_len2_reg)
        begin
            finish_verdict = ucc_pkg::VERDICT_EQUAL;
        end
        else if (ucc_pkg::is_bad_char(s1_first_reg))
        begin
            finish_verdict = cfg.error_value;
        end
        else
        begin
            finish_verdict = ucc_pkg::VERDICT_GREATER;
        end
    end

    always_comb
    begin
        settled_next     = settled_reg;
        held_next        = held_reg;
        out_decided_next = out_decided_reg;
        out_verdict_next = out_verdict_reg;
        if (advance)
        begin
            case (s1_cmd_reg)
                ucc_pkg::CMD_COMPARE:
                begin
                    if (!settled_reg)
                    begin
                        if (ucc_pkg::is_bad_char(map_first))
                        begin
                            settled_next = 1'b1;
                            held_next    = cfg.error_value;
                        end
                        else if (map_first < map_second)
                        begin
                            settled_next = 1'b1;
                            held_next    = ucc_pkg::VERDICT_LESS;
                        end
                        else if (map_first > map_second)
                        begin
                            settled_next = 1'b1;
                            held_next    = ucc_pkg::VERDICT_GREATER;
                        end
                    end
                end
                ucc_pkg::CMD_FINISH:
                begin
                    settled_next = 1'b0;
                    held_next    = '0;
                end
                default:
                begin
                end
            endcase

            if (s1_cmd_reg == ucc_pkg::CMD_FINISH)
            begin
                out_decided_next = 1'b1;
                out_verdict_next = finish_verdict;
            end
            else
            begin
                out_decided_next = settled_next;
                out_verdict_next = settled_next ? held_next : ucc_pkg::VERDICT_EQUAL;
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            settled_reg   <= 1'b0;
            held_reg      <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            settled_reg   <= settled_next;
            held_reg      <= held_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg    <= item.command;
            s1_first_reg  <= item.char_first;
            s1_second_reg <= item.char_second;
            s1_len1_reg   <= item.first_length;
            s1_len2_reg   <= item.second_length;
        end
        out_decided_reg <= out_decided_next;
        out_verdict_reg <= out_verdict_next;
    end

    assign result.valid   = out_valid_reg;
    assign result.decided = out_decided_reg;
    assign result.verdict = out_verdict_reg;

endmodule

@@ rtl/core/upcase_name_collator.sv @@
// A taken item beat is registered in the compare stage, and its result beat in the
// result register. Throughput: one item per cycle unless the result beat stalls;
// the table lookup register and the result register form the two stages, and the
// table RAM has two read ports.
// Reset clears the pipeline valids and the held verdict; configuration
// returns to its defaults. The upcase table is not cleared and holds junk until loaded.
module upcase_name_collator
(
    input  logic                        clk,
    input  logic                        rst_n,
    ucc_item_if.sink                    item,
    ucc_result_if.source                result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ucc_pkg::APB_AW-1:0]  paddr,
    input  logic [ucc_pkg::APB_DW-1:0]  pwdata,
    output logic [ucc_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    ucc_pkg::cfg_t cfg;

    ucc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ucc_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .item   (item),
        .result (result)
    );

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import ucc_pkg::*;

    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int          DRAIN_WAIT  = 4;
    // '"', '*', '<', '>' and '?' may not appear in a first name.
    localparam logic [CHAR_W-1:0] RESERVED_CHARS [5] =
        '{16'h0022, 16'h002A, 16'h003C, 16'h003E, 16'h003F};

    typedef struct {
        logic [1:0]        command;
        logic [CHAR_W-1:0] table_index;
        logic [CHAR_W-1:0] table_value;
        logic [CHAR_W-1:0] char_first;
        logic [CHAR_W-1:0] char_second;
        logic [LEN_W-1:0]  first_length;
        logic [LEN_W-1:0]  second_length;
    } name_item_t;

    typedef struct {
        logic                        decided;
        logic signed [VERDICT_W-1:0] verdict;
    } verdict_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    ucc_item_if   item_bus ();
    ucc_result_if result_bus ();

    upcase_name_collator dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_bus),
        .result  (result_bus),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the collator: upcase table, name-pair verdict and registers.
    logic [CHAR_W-1:0]           fold_table [TABLE_DEPTH];
    bit                          fold_loaded [TABLE_DEPTH];
    logic [CHAR_W-1:0]           loaded_chars [$];
    bit                          pair_settled;
    logic signed [VERDICT_W-1:0] pair_verdict;
    cfg_t                        cfg_shadow;

    verdict_t    expected_verdicts [$];
    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned result_hold;
    bit          sender_idle_on;
    bit          sink_idle_on;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        pair_settled              = 1'b0;
        pair_verdict              = '0;
        cfg_shadow.case_fold      = 1'b0;
        cfg_shadow.upcase_length  = '0;
        cfg_shadow.error_value    = ERROR_RESET;
        fail_count                = 0;
        cycle_count               = 0;
        result_hold               = 0;
        sender_idle_on            = 1'b1;
        sink_idle_on              = 1'b1;
        rst_n                    <= 1'b0;
        psel                     <= 1'b0;
        penable                  <= 1'b0;
        pwrite                   <= 1'b0;
        paddr                    <= '0;
        pwdata                   <= '0;
        item_bus.valid           <= 1'b0;
        item_bus.command         <= CMD_LOAD;
        item_bus.table_index     <= '0;
        item_bus.table_value     <= '0;
        item_bus.char_first      <= '0;
        item_bus.char_second     <= '0;
        item_bus.first_length    <= '0;
        item_bus.second_length   <= '0;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic logic is_reserved_char(input logic [CHAR_W-1:0] c);
        foreach (RESERVED_CHARS[i])
        begin
            if (c == RESERVED_CHARS[i])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
        if (cfg_shadow.case_fold && {1'b0, c} < cfg_shadow.upcase_length)
            return fold_table[c];
        return c;
    endfunction

    function automatic verdict_t collate(input name_item_t it);
        verdict_t                    res;
        logic [CHAR_W-1:0]           c1;
        logic [CHAR_W-1:0]           c2;
        logic signed [VERDICT_W-1:0] v;
        case (it.command)
            CMD_LOAD:
            begin
                fold_table[it.table_index] = it.table_value;
                if (!fold_loaded[it.table_index])
                begin
                    fold_loaded[it.table_index] = 1'b1;
                    loaded_chars.push_back(it.table_index);
                end
            end
            CMD_COMPARE:
            begin
                if (!pair_settled)
                begin
                    c1 = fold_char(it.char_first);
                    c2 = fold_char(it.char_second);
                    if (is_reserved_char(c1))
                    begin
                        pair_settled = 1'b1;
                        pair_verdict = cfg_shadow.error_value;
                    end
                    else if (c1 < c2)
                    begin
                        pair_settled = 1'b1;
                        pair_verdict = VERDICT_LESS;
                    end
                    else if (c1 > c2)
                    begin
                        pair_settled = 1'b1;
                        pair_verdict = VERDICT_GREATER;
                    end
                end
            end
            CMD_FINISH:
            begin
                if (pair_settled)
                    v = pair_verdict;
                else if (it.first_length < it.second_length)
                    v = VERDICT_LESS;
                else if (it.first_length == it.second_length)
                    v = VERDICT_EQUAL;
                else if (is_reserved_char(it.char_first))
                    v = cfg_shadow.error_value;
                else
                    v = VERDICT_GREATER;
                pair_settled = 1'b0;
                pair_verdict = '0;
                res.decided  = 1'b1;
                res.verdict  = v;
                return res;
            end
            default:
            begin
            end
        endcase
        res.decided = pair_settled;
        res.verdict = pair_settled ? pair_verdict : VERDICT_EQUAL;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Result side: ready generation and checking
    // ------------------------------------------------------------------

    initial
    begin
        int burst;
        burst = 0;
        result_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_hold != 0)
            begin
                result_hold = result_hold - 1;
                result_bus.ready <= 1'b0;
            end
            else if (burst != 0)
            begin
                burst = burst - 1;
                result_bus.ready <= 1'b0;
            end
            else if (sink_idle_on && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(0, 3);
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        verdict_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (expected_verdicts.size() == 0)
            begin
                $display("%0t MISMATCH unexpected beat: expected none, %s %0d verdict %0d",
                         $time, "actual decided", result_bus.decided,
                         result_bus.verdict);
                fail_count++;
            end
            else
            begin
                want = expected_verdicts.pop_front();
                if (result_bus.decided !== want.decided)
                begin
                    $display("%0t MISMATCH decided: expected %0d actual %0d",
                             $time, want.decided, result_bus.decided);
                    fail_count++;
                end
                if (result_bus.verdict !== want.verdict)
                begin
                    $display("%0t MISMATCH verdict: expected %0d actual %0d",
                             $time, want.verdict, result_bus.verdict);
                    fail_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    task automatic write_reg(input reg_idx_t idx, input logic [APB_DW-1:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_CASE_FOLD:     cfg_shadow.case_fold     = data[0];
            REG_UPCASE_LENGTH: cfg_shadow.upcase_length = data[ULEN_W-1:0];
            REG_ERROR_VALUE:   cfg_shadow.error_value   = data[VERDICT_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    task automatic configure(input logic ic, input int unsigned ulen,
                             input logic signed [VERDICT_W-1:0] ev);
        write_reg(REG_CASE_FOLD, APB_DW'(ic));
        write_reg(REG_UPCASE_LENGTH, APB_DW'(ulen));
        write_reg(REG_ERROR_VALUE, {{(APB_DW-VERDICT_W){1'b0}}, ev});
    endtask

    // Lowers valid and waits until every expected beat has been seen.
    task automatic wait_drain();
        item_bus.valid <= 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic send_item(input name_item_t it);
        int gap;
        if (sender_idle_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 4);
            item_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_bus.valid         <= 1'b1;
        item_bus.command       <= it.command;
        item_bus.table_index   <= it.table_index;
        item_bus.table_value   <= it.table_value;
        item_bus.char_first    <= it.char_first;
        item_bus.char_second   <= it.char_second;
        item_bus.first_length  <= it.first_length;
        item_bus.second_length <= it.second_length;
        do
            @(posedge clk);
        while (!item_bus.ready);
        expected_verdicts.push_back(collate(it));
    endtask

    function automatic name_item_t make_item(input logic [1:0] cmd,
                                             input logic [CHAR_W-1:0] idx,
                                             input logic [CHAR_W-1:0] val,
                                             input logic [CHAR_W-1:0] c1,
                                             input logic [CHAR_W-1:0] c2,
                                             input logic [LEN_W-1:0] l1,
                                             input logic [LEN_W-1:0] l2);
        name_item_t it;
        it.command       = cmd;
        it.table_index   = idx;
        it.table_value   = val;
        it.char_first    = c1;
        it.char_second   = c2;
        it.first_length  = l1;
        it.second_length = l2;
        return it;
    endfunction

    task automatic send_cmp(input logic [CHAR_W-1:0] c1, input logic [CHAR_W-1:0] c2);
        send_item(make_item(CMD_COMPARE, '0, '0, c1, c2, '0, '0));
    endtask

    task automatic send_fin(input logic [CHAR_W-1:0] c1, input logic [LEN_W-1:0] l1,
                            input logic [LEN_W-1:0] l2);
        send_item(make_item(CMD_FINISH, '0, '0, c1, '0, l1, l2));
    endtask

    task automatic send_load(input logic [CHAR_W-1:0] idx, input logic [CHAR_W-1:0] val);
        send_item(make_item(CMD_LOAD, idx, val, '0, '0, '0, '0));
    endtask

    // A character whose table entry is unwritten must never be looked up.
    function automatic logic [CHAR_W-1:0] safe_char(input logic [CHAR_W-1:0] c);
        if (!cfg_shadow.case_fold || {1'b0, c} >= cfg_shadow.upcase_length ||
            fold_loaded[c])
            return c;
        if (loaded_chars.size() == 0)
            return c;
        return loaded_chars[$urandom_range(0, loaded_chars.size() - 1)];
    endfunction

    function automatic logic [CHAR_W-1:0] pick_char();
        int                r;
        logic [CHAR_W-1:0] c;
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            case ($urandom_range(0, 2))
                0:       c = 16'h0041 + CHAR_W'($urandom_range(0, 25));
                1:       c = 16'h0061 + CHAR_W'($urandom_range(0, 25));
                default: c = 16'h0030 + CHAR_W'($urandom_range(0, 9));
            endcase
        end
        else if (r < 65)
            c = RESERVED_CHARS[$urandom_range(0, 4)];
        else if (r < 80 && loaded_chars.size() != 0)
            c = loaded_chars[$urandom_range(0, loaded_chars.size() - 1)];
        else
            c = CHAR_W'($urandom);
        return safe_char(c);
    endfunction

    // Second-name character: mostly the same, sometimes the other case,
    // a neighbor or anything at all.
    function automatic logic [CHAR_W-1:0] partner_char(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] p;
        case ($urandom_range(0, 11))
            0:       p = pick_char();
            1:       p = c + 1'b1;
            2:       p = c - 1'b1;
            3, 4:    p = ((c | 16'h0020) >= 16'h0061 && (c | 16'h0020) <= 16'h007A) ?
                         (c ^ 16'h0020) : c;
            default: p = c;
        endcase
        return safe_char(p);
    endfunction

    function automatic name_item_t noise_item();
        logic [1:0] cmd;
        cmd = ($urandom_range(0, 19) == 0) ? CMD_UNUSED : 2'($urandom_range(0, 2));
        return make_item(cmd, CHAR_W'($urandom), CHAR_W'($urandom),
                         safe_char(CHAR_W'($urandom)), safe_char(CHAR_W'($urandom)),
                         LEN_W'($urandom), LEN_W'($urandom));
    endfunction

    function automatic int pick_len();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 20) : $urandom_range(0, 6);
    endfunction

    // Streams name pairs: compare beats over the common part, then a finish.
    task automatic run_names(input int unsigned budget);
        int unsigned       sent;
        int                n1;
        int                n2;
        int                common;
        logic [CHAR_W-1:0] c1;
        logic [CHAR_W-1:0] tail;
        sent = 0;
        while (sent < budget)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                send_item(noise_item());
                sent++;
            end
            else
            begin
                n1     = pick_len();
                n2     = ($urandom_range(0, 2) == 0) ? pick_len() : n1;
                common = (n1 < n2) ? n1 : n2;
                for (int i = 0; i < common; i++)
                begin
                    c1 = pick_char();
                    send_cmp(c1, partner_char(c1));
                    sent++;
                end
                tail = pick_char();
                // Now and then the finish is dropped and the next pair runs on.
                if ($urandom_range(0, 9) != 0)
                begin
                    if ($urandom_range(0, 7) == 0)
                        send_fin(tail, LEN_W'($urandom), LEN_W'($urandom));
                    else
                        send_fin(tail, LEN_W'(n1), LEN_W'(n2));
                    sent++;
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_reset_defaults();
        send_cmp(16'h0000, 16'hFFFF);
        send_cmp(16'hFFFF, 16'h0000);           // ignored, verdict already held
        send_fin(16'h0000, 8'd255, 8'd0);
        send_cmp(16'hFFFF, 16'h0000);
        send_fin(16'h0000, 8'd0, 8'd255);
        send_cmp(16'h0041, 16'h0041);
        send_cmp(16'h002A, 16'h002A);           // invalid first character
        send_item(make_item(CMD_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                            8'hFF, 8'hFF));
        send_fin(16'h0041, 8'd1, 8'd1);
        send_cmp(16'h0041, 16'h0022);           // invalid second character is fine
        send_fin(16'h0041, 8'd1, 8'd1);
        send_cmp(16'h0042, 16'h0042);
        send_fin(16'h0042, 8'd3, 8'd3);
        send_fin(16'h0041, 8'd2, 8'd3);
        send_fin(16'h003F, 8'd4, 8'd3);         // longer first name, invalid next char
        send_fin(16'h007A, 8'd4, 8'd3);
        send_item(make_item(CMD_UNUSED, '0, '0, '0, '0, '0, '0));
        send_load(16'hFFFF, 16'h0000);
        send_load(16'h0000, 16'hFFFF);
        wait_drain();
    endtask

    // ASCII upcase entries, with '!' folding onto '?' and '~' onto the top code.
    task automatic test_table_load();
        logic [CHAR_W-1:0] v;
        for (int i = 0; i < 128; i++)
        begin
            if (i >= 16'h0061 && i <= 16'h007A)
                v = CHAR_W'(i - 32);
            else if (i == 16'h0021)
                v = 16'h003F;
            else if (i == 16'h007E)
                v = 16'hFFFF;
            else
                v = CHAR_W'(i);
            send_load(CHAR_W'(i), v);
        end
        send_load(16'hFFFF, 16'hFFFF);
        send_load(16'h8000, 16'h7FFF);
        for (int i = 0; i < 12; i++)
            send_load(CHAR_W'($urandom), CHAR_W'($urandom));
        wait_drain();
    endtask

    task automatic test_case_fold();
        configure(1'b1, 128, ERROR_RESET);
        send_cmp(16'h0061, 16'h0041);
        send_cmp(16'h0042, 16'h0062);
        send_fin(16'h0000, 8'd2, 8'd2);
        send_cmp(16'h0021, 16'h0041);           // folds onto an invalid character
        send_fin(16'h0000, 8'd1, 8'd1);
        send_fin(16'h0021, 8'd3, 8'd2);         // finish looks at the raw character
        send_cmp(16'h007E, 16'h0041);
        send_fin(16'h0000, 8'd1, 8'd1);
        send_cmp(16'hFFFF, 16'h007E);           // above the table length, unchanged
        send_fin(16'h0000, 8'd1, 8'd1);
        wait_drain();
        // Length right at 'a': lowercase letters pass unchanged.
        configure(1'b1, 16'h0061, ERROR_RESET);
        send_cmp(16'h0060, 16'h0060);
        send_cmp(16'h0061, 16'h0041);
        send_fin(16'h0000, 8'd2, 8'd2);
        wait_drain();
    endtask

    task automatic test_error_extremes();
        configure(1'b0, 0, -8'sd128);
        send_cmp(16'h003C, 16'h0000);
        send_fin(16'h0000, 8'd1, 8'd1);
        send_fin(16'h0022, 8'd9, 8'd8);
        wait_drain();
        configure(1'b1, 65536, 8'sd127);
        send_cmp(16'h003E, 16'h003E);
        send_fin(16'h0000, 8'd1, 8'd1);
        send_fin(16'h003F, 8'd200, 8'd100);
        wait_drain();
    endtask

    task automatic test_random_settings();
        configure(1'b1, 128, ERROR_RESET);
        run_names(150);
        wait_drain();
        configure(1'b0, 65536, 8'sd127);
        run_names(150);
        wait_drain();
        configure(1'b1, 65536, -8'sd128);
        run_names(150);
        wait_drain();
        configure(1'b1, 16'h0061, 8'sd0);
        run_names(150);
        wait_drain();
        configure(1'b1, 0, 8'sd5);
        run_names(150);
        wait_drain();
    endtask

    // The sink holds off while the source keeps offering, so the pipeline fills.
    task automatic test_backpressure();
        configure(1'b1, 128, -8'sd3);
        sender_idle_on = 1'b0;
        result_hold    = 300;
        run_names(60);
        wait_drain();
        sender_idle_on = 1'b1;
        run_names(40);
        wait_drain();
    endtask

    task automatic test_steady_stream();
        sender_idle_on = 1'b0;
        sink_idle_on   = 1'b0;
        configure(1'b1, 128, ERROR_RESET);
        run_names(150);
        wait_drain();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_table_load();
        test_case_fold();
        test_error_extremes();
        test_random_settings();
        test_backpressure();
        test_steady_stream();
        repeat (10) @(posedge clk);
        if (fail_count == 0 && expected_verdicts.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
